// ===== hdl/jfd_pkg.sv =====
// ----------------------------------------------------------------------------
// jfd_pkg
// Shared types and constants for the serial frame deframer.
// ----------------------------------------------------------------------------
package jfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int TDATA_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hE0;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hD0;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SYNC   = 1'b0,
    REG_ESCAPE = 1'b1
  } reg_index_t;

  // Result kinds carried on tuser.
  typedef enum logic [0:0] {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_SUM  = 3'd4
  } phase_t;

  // Decoded byte handed from the escape decoder to the framer.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] value;
  } dec_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] frame_address;
    logic [BYTE_W-1:0] byte_index;
    logic              checksum_ok;
  } result_t;

endpackage

// ===== hdl/jvs_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// jvs_frame_deframer_unit
// Deframes an escaped serial byte stream into payload bytes and frame ends.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle whenever s_tready is high; each non-escape
// byte is decoded and advances the frame state in the cycle it is accepted,
// so the block sustains one byte per clock while s_tready is high. Each
// payload or checksum byte makes one master request, queued in a two-entry
// buffer; s_tready drops only while both entries wait on m_tready. Escape
// and header bytes produce nothing. The user must set sync and escape values
// via the cfg port only while the stream is idle; the block does not enforce it.
module jvs_frame_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [jfd_pkg::BYTE_W-1:0]  cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [jfd_pkg::TDATA_W-1:0] m_tdata,  // [7:0] data_byte,
                                                // [15:8] frame_address,
                                                // [23:16] byte_index,
                                                // [24] checksum_ok, rest zero
  output logic                        m_tuser   // [0] result_kind
);

  logic [jfd_pkg::BYTE_W-1:0] sync_byte;
  logic [jfd_pkg::BYTE_W-1:0] escape_byte;
  logic                       accept;
  jfd_pkg::dec_t              dec;
  logic                       res_valid;
  jfd_pkg::result_t           res;
  jfd_pkg::result_t           head_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte   <= jfd_pkg::SYNC_RESET;
      escape_byte <= jfd_pkg::ESCAPE_RESET;
    end else if (cfg_we) begin
      case (jfd_pkg::reg_index_t'(cfg_index))
        jfd_pkg::REG_SYNC:   sync_byte   <= cfg_data;
        jfd_pkg::REG_ESCAPE: escape_byte <= cfg_data;
        default:             sync_byte   <= sync_byte;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  jfd_escape_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .escape_byte (escape_byte),
    .dec         (dec)
  );

  jfd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .dec       (dec),
    .sync_byte (sync_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  jfd_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_res (res),
    .space    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head_res (head_res)
  );

  assign m_tuser = head_res.kind;
  assign m_tdata = {7'd0, head_res.checksum_ok, head_res.byte_index,
                    head_res.frame_address, head_res.data_byte};

endmodule

// ===== hdl/jfd_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// jfd_escape_decoder
// Removes escape bytes and adds one to the byte that follows each of them.
// ----------------------------------------------------------------------------
module jfd_escape_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [jfd_pkg::BYTE_W-1:0] rx_byte,
  input  logic [jfd_pkg::BYTE_W-1:0] escape_byte,
  output jfd_pkg::dec_t              dec
);

  logic escape_pending;
  logic escape_pending_next;

  always_comb begin
    dec.valid = escape_pending || (rx_byte != escape_byte);
    dec.value = escape_pending ? (rx_byte + jfd_pkg::BYTE_W'(1)) : rx_byte;
    escape_pending_next = !escape_pending && (rx_byte == escape_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ===== hdl/jfd_framer.sv =====
// ----------------------------------------------------------------------------
// jfd_framer
// Frame state machine: sync hunt, address, length, payload and checksum.
// ----------------------------------------------------------------------------
module jfd_framer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  jfd_pkg::dec_t              dec,
  input  logic [jfd_pkg::BYTE_W-1:0] sync_byte,
  output logic                       res_valid,
  output jfd_pkg::result_t           res
);

  jfd_pkg::phase_t           phase;
  jfd_pkg::phase_t           phase_next;
  logic [jfd_pkg::BYTE_W-1:0] address_hold;
  logic [jfd_pkg::BYTE_W-1:0] bytes_left;
  logic [jfd_pkg::BYTE_W-1:0] payload_position;
  logic [jfd_pkg::BYTE_W-1:0] running_sum;
  logic [jfd_pkg::BYTE_W-1:0] sum_plus;
  logic                       step;

  assign step     = accept && dec.valid;
  assign sum_plus = running_sum + dec.value;

  always_comb begin
    case (phase)
      jfd_pkg::PH_ADDR: phase_next = jfd_pkg::PH_LEN;
      // A length of one means an empty payload.
      jfd_pkg::PH_LEN:  phase_next = (dec.value != jfd_pkg::BYTE_W'(1)) ?
                                     jfd_pkg::PH_DATA : jfd_pkg::PH_SUM;
      jfd_pkg::PH_DATA: phase_next = (bytes_left == jfd_pkg::BYTE_W'(1)) ?
                                     jfd_pkg::PH_SUM : jfd_pkg::PH_DATA;
      jfd_pkg::PH_SUM:  phase_next = jfd_pkg::PH_HUNT;
      default:          phase_next = (dec.value == sync_byte) ?
                                     jfd_pkg::PH_ADDR : jfd_pkg::PH_HUNT;
    endcase
  end

  always_comb begin
    res_valid         = 1'b0;
    res.kind          = jfd_pkg::KIND_PAYLOAD;
    res.data_byte     = dec.value;
    res.frame_address = address_hold;
    res.byte_index    = payload_position;
    res.checksum_ok   = 1'b0;
    case (phase)
      jfd_pkg::PH_DATA: begin
        res_valid = step;
      end
      jfd_pkg::PH_SUM: begin
        res_valid       = step;
        res.kind        = jfd_pkg::KIND_FRAME_END;
        res.data_byte   = '0;
        res.checksum_ok = (dec.value == running_sum);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jfd_pkg::PH_HUNT;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_hold     <= '0;
      bytes_left       <= '0;
      payload_position <= '0;
      running_sum      <= '0;
    end else if (step) begin
      case (phase)
        jfd_pkg::PH_ADDR: begin
          address_hold <= dec.value;
          running_sum  <= dec.value;
        end
        jfd_pkg::PH_LEN: begin
          running_sum      <= sum_plus;
          bytes_left       <= dec.value - jfd_pkg::BYTE_W'(1);
          payload_position <= '0;
        end
        jfd_pkg::PH_DATA: begin
          running_sum      <= sum_plus;
          bytes_left       <= bytes_left - jfd_pkg::BYTE_W'(1);
          payload_position <= payload_position + jfd_pkg::BYTE_W'(1);
        end
        default: begin
          running_sum <= running_sum;
        end
      endcase
    end
  end

endmodule

// ===== hdl/jfd_out_queue.sv =====
// ----------------------------------------------------------------------------
// jfd_out_queue
// Two-entry result queue that decouples the output stall from input ready.
// ----------------------------------------------------------------------------
module jfd_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jfd_pkg::result_t push_res,
  output logic             space,
  output logic             m_tvalid,
  input  logic             m_tready,
  output jfd_pkg::result_t head_res
);

  jfd_pkg::result_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  // Ready depends only on the fill level, so no path runs from m_tready.
  assign space    = (count != 2'd2);
  assign head_res = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/jfd_checker.sv =====
// ----------------------------------------------------------------------------
// jfd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module jfd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [jfd_pkg::TDATA_W-1:0] m_tdata,
  input logic                        m_tuser
);

  // A stalled request keeps its valid.
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // A stalled request keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("master payload changed while stalled");

  // A frame end never carries a data byte.
  a_end_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("frame end carries a nonzero data byte");

  // A payload byte never claims a checksum verdict.
  a_payload_no_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tdata[24])
    else $error("payload byte has checksum_ok set");

  // Reset empties the result queue and opens the input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("queue not empty after reset");

endmodule

bind jvs_frame_deframer_unit jfd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
